### src/bdh_pkg.sv
// Shared types, codes and reset constants for the button debounce and hold detector.
// Used by every module of the block; depends on nothing else.
package bdh_pkg;

   // Field widths
   localparam int CFG_W        = 16;
   localparam int CMD_W        = 2;
   localparam int SEL_W        = 2;
   localparam int STATE_W      = 3;
   localparam int NUM_SLOTS    = 3;
   localparam int FLAG_W       = 4;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   // Defaults
   localparam int                BDH_COUNTER_WIDTH = 16;
   localparam logic [CFG_W-1:0]  DEBOUNCE_RESET    = 16'd100;
   localparam logic [CFG_W-1:0]  HOLD_RESET        = 16'd1000;
   localparam logic              TESTING_RESET     = 1'b0;

   // Register indexes on the CSR port
   typedef enum logic [1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_HOLD     = 2'd1,
      REG_TESTING  = 2'd2
   } bdh_reg_type;

   // Item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK      = 2'd0,
      CMD_ENC_STEP  = 2'd1,
      CMD_READ      = 2'd2,
      CMD_CLR_BREAK = 2'd3
   } bdh_cmd_type;

   // Flag slots
   localparam logic [SEL_W-1:0] SLOT_LEFT  = 2'd0;
   localparam logic [SEL_W-1:0] SLOT_MAIN  = 2'd1;
   localparam logic [SEL_W-1:0] SLOT_RIGHT = 2'd2;

   // Bit positions inside a slot
   localparam int F_PUSHED   = 0;
   localparam int F_CLICKED  = 1;
   localparam int F_HOLD     = 2;
   localparam int F_RELEASED = 3;

   // Debounce states
   typedef enum logic [STATE_W-1:0] {
      ST_RELEASED = 3'd0,
      ST_PUSH_DB  = 3'd1,
      ST_HOLD     = 3'd2,
      ST_PUSHED   = 3'd3,
      ST_REL_DB   = 3'd4
   } bdh_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] hold_ticks;
      logic             testing_mode;
   } bdh_cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             pressed;
      logic             enc_dir;
      logic [SEL_W-1:0] button_sel;
   } bdh_item_type;

   typedef struct packed {
      logic [STATE_W-1:0] fsm_state;
      logic               hold_active;
      logic               break_pending;
      logic [FLAG_W-1:0]  flags;
   } bdh_result_type;

   // Main-slot flag changes caused by one tick
   typedef struct packed {
      logic set_pushed;
      logic clr_pushed;
      logic set_clicked;
      logic set_hold;
      logic set_released;
      logic clr_released;
   } bdh_flag_evt_type;

endpackage

### src/bdh_csr.sv
// APB-style configuration registers of the button debounce and hold detector.
// Depends on bdh_pkg.
module bdh_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bdh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bdh_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bdh_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output bdh_pkg::bdh_cfg_type           cfg
);
   import bdh_pkg::*;

   logic [CFG_W-1:0] debounce_ff, debounce_in;
   logic [CFG_W-1:0] hold_ff, hold_in;
   logic             testing_ff, testing_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode the write beat
   always_comb begin
      debounce_in = debounce_ff;
      hold_in     = hold_ff;
      testing_in  = testing_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DEBOUNCE: debounce_in = csr_pwdata[CFG_W-1:0];
            REG_HOLD:     hold_in     = csr_pwdata[CFG_W-1:0];
            REG_TESTING:  testing_in  = csr_pwdata[0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         hold_ff     <= HOLD_RESET;
         testing_ff  <= TESTING_RESET;
      end else begin
         debounce_ff <= debounce_in;
         hold_ff     <= hold_in;
         testing_ff  <= testing_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_DEBOUNCE: csr_prdata = CSR_DATA_W'(debounce_ff);
         REG_HOLD:     csr_prdata = CSR_DATA_W'(hold_ff);
         REG_TESTING:  csr_prdata = CSR_DATA_W'(testing_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.debounce_ticks = debounce_ff;
   assign cfg.hold_ticks     = hold_ff;
   assign cfg.testing_mode   = testing_ff;

endmodule

### src/bdh_engine.sv
// Debounce state machine, elapsed-tick counter, slot flags and break flag.
// Computes one item's result from the held state; depends on bdh_pkg.
module bdh_engine #(
   parameter int COUNTER_WIDTH = bdh_pkg::BDH_COUNTER_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  bdh_pkg::bdh_item_type   item,
   input  bdh_pkg::bdh_cfg_type    cfg,
   output bdh_pkg::bdh_result_type result
);
   import bdh_pkg::*;

   localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

   bdh_state_type          state_ff, state_in;
   logic [COUNTER_WIDTH-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic [FLAG_W-1:0]      slot_ff [NUM_SLOTS];
   logic [FLAG_W-1:0]      slot_in [NUM_SLOTS];
   logic                   break_ff, break_in;
   logic                   is_tick;
   logic                   deb_wait, hold_wait;
   logic                   sel_ok;
   logic [FLAG_W-1:0]      rd_flags;
   logic [FLAG_W-1:0]      main_set, main_clr;
   bdh_flag_evt_type       evt;

   assign is_tick     = (item.cmd == CMD_TICK);
   // Saturating increment of the elapsed counter
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff
                                           : elapsed_ff + COUNTER_WIDTH'(1);
   assign deb_wait    = CMP_W'(elapsed_inc) < CMP_W'(cfg.debounce_ticks);
   assign hold_wait   = CMP_W'(elapsed_inc) < CMP_W'(cfg.hold_ticks);

   // Next state and counter
   always_comb begin
      state_in   = state_ff;
      elapsed_in = elapsed_ff;
      if (is_tick) begin
         elapsed_in = elapsed_inc;
         case (state_ff)
            ST_RELEASED: begin
               if (item.pressed) begin
                  state_in   = ST_PUSH_DB;
                  elapsed_in = '0;
               end
            end
            ST_PUSH_DB: begin
               if (!deb_wait) begin
                  elapsed_in = '0;
                  state_in   = item.pressed ? ST_HOLD : ST_REL_DB;
               end
            end
            ST_HOLD: begin
               if (!hold_wait) begin
                  state_in   = ST_PUSHED;
                  elapsed_in = '0;
               end else if (!item.pressed) begin
                  state_in   = ST_REL_DB;
                  elapsed_in = '0;
               end
            end
            ST_PUSHED: begin
               if (!item.pressed) begin
                  state_in   = ST_REL_DB;
                  elapsed_in = '0;
               end
            end
            ST_REL_DB: begin
               if (!deb_wait) begin
                  state_in = item.pressed ? ST_PUSHED : ST_RELEASED;
               end
            end
            default: state_in = ST_RELEASED;
         endcase
      end
   end

   // Main-slot flag events of the transition
   always_comb begin
      evt = '0;
      if (is_tick) begin
         case (state_ff)
            ST_RELEASED: begin
               if (item.pressed) begin
                  evt.set_pushed   = 1'b1;
                  evt.clr_released = 1'b1;
               end
            end
            ST_PUSH_DB: begin
               if (!deb_wait) begin
                  evt.set_clicked  = item.pressed;
                  evt.clr_pushed   = !item.pressed;
                  evt.set_released = !item.pressed;
               end
            end
            ST_HOLD: begin
               if (!hold_wait) begin
                  evt.set_hold = 1'b1;
               end else if (!item.pressed) begin
                  evt.clr_pushed   = 1'b1;
                  evt.set_released = 1'b1;
               end
            end
            ST_REL_DB: begin
               if (!deb_wait && !item.pressed) begin
                  evt.clr_pushed   = 1'b1;
                  evt.set_released = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign main_set = {evt.set_released, evt.set_hold, evt.set_clicked, evt.set_pushed};
   assign main_clr = {evt.clr_released, 1'b0, 1'b0, evt.clr_pushed};

   // Slot read and slot updates
   assign sel_ok   = (item.button_sel inside {SLOT_LEFT, SLOT_MAIN, SLOT_RIGHT});
   assign rd_flags = (item.cmd == CMD_READ && sel_ok) ? slot_ff[item.button_sel] : '0;

   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         slot_in[s] = slot_ff[s];
      end
      slot_in[SLOT_MAIN] = (slot_ff[SLOT_MAIN] & ~main_clr) | main_set;
      case (item.cmd)
         CMD_ENC_STEP: begin
            if (item.enc_dir) begin
               slot_in[SLOT_RIGHT][F_CLICKED]  = 1'b1;
               slot_in[SLOT_RIGHT][F_RELEASED] = 1'b1;
            end else begin
               slot_in[SLOT_LEFT][F_CLICKED]  = 1'b1;
               slot_in[SLOT_LEFT][F_RELEASED] = 1'b1;
            end
         end
         CMD_READ: begin
            if (rd_flags[F_RELEASED]) begin
               slot_in[item.button_sel] = '0;
            end
         end
         default: ;
      endcase
   end

   // Break-pending flag
   always_comb begin
      break_in = break_ff;
      if (item.cmd == CMD_CLR_BREAK) begin
         break_in = 1'b0;
      end else if (is_tick && cfg.testing_mode && state_in == ST_HOLD) begin
         break_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RELEASED;
         elapsed_ff <= '0;
         break_ff   <= 1'b0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_ff[s] <= '0;
         end
      end else if (fire) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         break_ff   <= break_in;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_ff[s] <= slot_in[s];
         end
      end
   end

   assign result.fsm_state     = state_in;
   assign result.hold_active   = (state_in == ST_HOLD);
   assign result.break_pending = break_in;
   assign result.flags         = rd_flags;

endmodule

### src/button_debounce_hold_detector_core.sv
// Button debounce and long-press detector: one input item per cycle while no result waits
// on rsp_stall, one result per item. An item is registered on acceptance; its state update
// and result are formed once the result register is free and held in that register, so
// the block sustains one item per clock while rsp_stall is low; the input register lets a new item in
// while a result waits on rsp_stall. Depends on bdh_pkg, bdh_csr and bdh_engine.
module button_debounce_hold_detector_core #(
   parameter int COUNTER_WIDTH = bdh_pkg::BDH_COUNTER_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bdh_pkg::CMD_W-1:0]      req_cmd,
   input  logic                           req_pressed,
   input  logic                           req_enc_dir,
   input  logic [bdh_pkg::SEL_W-1:0]      req_button_sel,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bdh_pkg::STATE_W-1:0]    rsp_fsm_state,
   output logic                           rsp_hold_active,
   output logic                           rsp_break_pending,
   output logic                           rsp_flag_pushed,
   output logic                           rsp_flag_clicked,
   output logic                           rsp_flag_hold,
   output logic                           rsp_flag_released,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bdh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bdh_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bdh_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bdh_pkg::*;

   logic           in_v_ff, in_v_in;
   bdh_item_type   in_item_ff;
   logic           rsp_v_ff, rsp_v_in;
   bdh_result_type rsp_ff;
   bdh_result_type result;
   bdh_cfg_type    cfg;
   logic           out_free, fire, req_take;

   bdh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bdh_engine #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Handshake: advance the held item whenever the result register frees up
   assign out_free  = !rsp_v_ff || !rsp_stall;
   assign fire      = in_v_ff && out_free;
   assign req_stall = in_v_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_v_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_v_ff);
   assign rsp_v_in = fire ? 1'b1 : (rsp_stall ? rsp_v_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.cmd        <= req_cmd;
         in_item_ff.pressed    <= req_pressed;
         in_item_ff.enc_dir    <= req_enc_dir;
         in_item_ff.button_sel <= req_button_sel;
      end
   end

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_v_ff;
   assign rsp_fsm_state     = rsp_ff.fsm_state;
   assign rsp_hold_active   = rsp_ff.hold_active;
   assign rsp_break_pending = rsp_ff.break_pending;
   assign rsp_flag_pushed   = rsp_ff.flags[F_PUSHED];
   assign rsp_flag_clicked  = rsp_ff.flags[F_CLICKED];
   assign rsp_flag_hold     = rsp_ff.flags[F_HOLD];
   assign rsp_flag_released = rsp_ff.flags[F_RELEASED];

endmodule

### src/bdh_checker.sv
// Port-level checks for the button debounce and hold detector, bound to its top level.
// Depends on bdh_pkg and button_debounce_hold_detector_core.
module bdh_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [bdh_pkg::STATE_W-1:0] rsp_fsm_state,
   input logic                        rsp_hold_active,
   input logic                        rsp_flag_pushed,
   input logic                        rsp_flag_clicked,
   input logic                        rsp_flag_hold,
   input logic                        rsp_flag_released
);
   import bdh_pkg::*;

   // A stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fsm_state)
                                 && $stable(rsp_flag_released))
      else $error("result beat changed under stall");

   // An empty result register never back-pressures the input
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // hold_active mirrors the reported state
   a_hold_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hold_active == (rsp_fsm_state == ST_HOLD)))
      else $error("hold_active disagrees with state");

   // Hold is only ever reported together with the click that preceded it
   a_hold_clicked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flag_hold |-> rsp_flag_clicked)
      else $error("hold flag without clicked flag");

   // Pushed and released exclude each other
   a_push_rel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_flag_pushed && rsp_flag_released))
      else $error("pushed and released both set");

endmodule

bind button_debounce_hold_detector_core bdh_checker u_bdh_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_fsm_state     (rsp_fsm_state),
   .rsp_hold_active   (rsp_hold_active),
   .rsp_flag_pushed   (rsp_flag_pushed),
   .rsp_flag_clicked  (rsp_flag_clicked),
   .rsp_flag_hold     (rsp_flag_hold),
   .rsp_flag_released (rsp_flag_released)
);

### tb/bdh_button_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the button debounce and hold detector: mirrors the debounce machine,
// the three event flag slots and the break flag, and checks every result beat in order.
// Depends on bdh_pkg; watches the item, result and CSR ports of the core.
module bdh_button_checker #(
   parameter int COUNTER_WIDTH = bdh_pkg::BDH_COUNTER_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [bdh_pkg::CMD_W-1:0]      req_cmd,
   input  logic                           req_pressed,
   input  logic                           req_enc_dir,
   input  logic [bdh_pkg::SEL_W-1:0]      req_button_sel,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [bdh_pkg::STATE_W-1:0]    rsp_fsm_state,
   input  logic                           rsp_hold_active,
   input  logic                           rsp_break_pending,
   input  logic                           rsp_flag_pushed,
   input  logic                           rsp_flag_clicked,
   input  logic                           rsp_flag_hold,
   input  logic                           rsp_flag_released,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bdh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bdh_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [bdh_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             pending_beats,
   output int                             fail_total
);
   import bdh_pkg::*;

   localparam longint TICK_MAX = (longint'(1) << COUNTER_WIDTH) - 1;

   // Register copies
   logic [CFG_W-1:0] deb_limit;
   logic [CFG_W-1:0] hold_limit;
   logic             test_mode;

   // Mirrored block state
   bdh_state_type    btn_state;
   longint           elapsed;
   logic [FLAG_W-1:0] slot_flags [NUM_SLOTS];
   logic             brk_flag;

   bdh_result_type   predicted_status_q[$];
   int               fail_count = 0;
   int               beat_no = 0;

   assign fail_total = fail_count;

   task automatic log_fault(string msg);
      fail_count++;
      $display("[%0t] result beat %0d: %s", $realtime, beat_no, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         log_fault($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Drop pushed, raise released on the main button slot
   function automatic void note_release();
      slot_flags[SLOT_MAIN][F_PUSHED]   = 1'b0;
      slot_flags[SLOT_MAIN][F_RELEASED] = 1'b1;
   endfunction

   // Advance the debounce machine by one pin sample
   function automatic void tick_button(logic pin);
      if (elapsed < TICK_MAX)
         elapsed++;
      case (btn_state)
         ST_RELEASED: begin
            if (pin) begin
               slot_flags[SLOT_MAIN][F_PUSHED]   = 1'b1;
               slot_flags[SLOT_MAIN][F_RELEASED] = 1'b0;
               elapsed   = 0;
               btn_state = ST_PUSH_DB;
            end
         end
         ST_PUSH_DB: begin
            if (elapsed >= longint'(deb_limit)) begin
               elapsed = 0;
               if (pin) begin
                  slot_flags[SLOT_MAIN][F_CLICKED] = 1'b1;
                  btn_state = ST_HOLD;
               end else begin
                  note_release();
                  btn_state = ST_REL_DB;
               end
            end
         end
         ST_HOLD: begin
            if (elapsed < longint'(hold_limit)) begin
               // early let-go during the hold wait
               if (!pin) begin
                  note_release();
                  elapsed   = 0;
                  btn_state = ST_REL_DB;
               end
            end else begin
               slot_flags[SLOT_MAIN][F_HOLD] = 1'b1;
               elapsed   = 0;
               btn_state = ST_PUSHED;
            end
         end
         ST_PUSHED: begin
            if (!pin) begin
               elapsed   = 0;
               btn_state = ST_REL_DB;
            end
         end
         ST_REL_DB: begin
            if (elapsed >= longint'(deb_limit)) begin
               if (!pin) begin
                  note_release();
                  btn_state = ST_RELEASED;
               end else begin
                  btn_state = ST_PUSHED;
               end
            end
         end
         default: btn_state = ST_RELEASED;
      endcase
      if (test_mode && btn_state == ST_HOLD)
         brk_flag = 1'b1;
   endfunction

   // Apply one item to the mirrored state and form the status it returns
   function automatic bdh_result_type step_button(bdh_cmd_type cmd, logic pin, logic dir,
                                                  logic [SEL_W-1:0] sel);
      bdh_result_type    status;
      logic [FLAG_W-1:0] seen;
      logic [SEL_W-1:0]  slot;
      seen = '0;
      case (cmd)
         CMD_TICK: tick_button(pin);
         CMD_ENC_STEP: begin
            slot = dir ? SLOT_RIGHT : SLOT_LEFT;
            slot_flags[slot][F_CLICKED]  = 1'b1;
            slot_flags[slot][F_RELEASED] = 1'b1;
         end
         CMD_READ: begin
            // a read of the missing fourth slot returns zeros and changes nothing
            if (sel < NUM_SLOTS) begin
               seen = slot_flags[sel];
               if (seen[F_RELEASED])
                  slot_flags[sel] = '0;
            end
         end
         default: brk_flag = 1'b0;
      endcase
      status.fsm_state     = btn_state;
      status.hold_active   = (btn_state == ST_HOLD);
      status.break_pending = brk_flag;
      status.flags         = seen;
      return status;
   endfunction

   always @(posedge clock) begin : watch_beats
      bdh_result_type        want;
      bdh_reg_type           reg_idx;
      logic [CSR_DATA_W-1:0] want_word;
      if (reset) begin
         deb_limit  = DEBOUNCE_RESET;
         hold_limit = HOLD_RESET;
         test_mode  = TESTING_RESET;
         btn_state  = ST_RELEASED;
         elapsed    = 0;
         foreach (slot_flags[i])
            slot_flags[i] = '0;
         brk_flag = 1'b0;
         predicted_status_q.delete();
         pending_beats <= 0;
      end else begin
         reg_idx = bdh_reg_type'(csr_paddr[3:2]);

         // Track register writes and check read data on the access edge
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (reg_idx)
                  REG_DEBOUNCE: deb_limit  = csr_pwdata[CFG_W-1:0];
                  REG_HOLD:     hold_limit = csr_pwdata[CFG_W-1:0];
                  REG_TESTING:  test_mode  = csr_pwdata[0];
                  default: ;
               endcase
            end else begin
               case (reg_idx)
                  REG_DEBOUNCE: want_word = CSR_DATA_W'(deb_limit);
                  REG_HOLD:     want_word = CSR_DATA_W'(hold_limit);
                  default:      want_word = CSR_DATA_W'(test_mode);
               endcase
               if (csr_prdata !== want_word)
                  log_fault($sformatf("register %s reads %0h, expected %0h",
                                      reg_idx.name(), csr_prdata, want_word));
            end
         end

         // Compare the result beat with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (predicted_status_q.size() == 0) begin
               log_fault("result beat with no item outstanding");
            end else begin
               want = predicted_status_q.pop_front();
               check_field("fsm_state", 32'(rsp_fsm_state), 32'(want.fsm_state));
               check_field("hold_active", 32'(rsp_hold_active), 32'(want.hold_active));
               check_field("break_pending", 32'(rsp_break_pending),
                           32'(want.break_pending));
               check_field("flag_pushed", 32'(rsp_flag_pushed),
                           32'(want.flags[F_PUSHED]));
               check_field("flag_clicked", 32'(rsp_flag_clicked),
                           32'(want.flags[F_CLICKED]));
               check_field("flag_hold", 32'(rsp_flag_hold), 32'(want.flags[F_HOLD]));
               check_field("flag_released", 32'(rsp_flag_released),
                           32'(want.flags[F_RELEASED]));
            end
            beat_no++;
         end

         // Predict the status of each accepted item
         if (req_valid && !req_stall)
            predicted_status_q.push_back(step_button(bdh_cmd_type'(req_cmd), req_pressed,
                                                     req_enc_dir, req_button_sel));
         pending_beats <= predicted_status_q.size();
      end
   end

endmodule

### tb/tb_button_debounce_hold_detector_core.sv
`timescale 1ns / 100ps
// Testbench top for the button debounce and hold detector: clock, reset, register
// settings per phase, item stimulus with random gaps and result stalls, and the verdict.
// Depends on bdh_pkg, button_debounce_hold_detector_core and bdh_button_checker.
module tb_button_debounce_hold_detector_core;
   import bdh_pkg::*;

   localparam int               PHASES      = 8;
   localparam int               PHASE_ITEMS = 103;
   localparam int               QUIET_LIMIT = 2000;
   localparam logic [SEL_W-1:0] SEL_NONE    = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_cmd = CMD_TICK;
   logic                  req_pressed = 1'b0;
   logic                  req_enc_dir = 1'b0;
   logic [SEL_W-1:0]      req_button_sel = SLOT_LEFT;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATE_W-1:0]    rsp_fsm_state;
   logic                  rsp_hold_active;
   logic                  rsp_break_pending;
   logic                  rsp_flag_pushed;
   logic                  rsp_flag_clicked;
   logic                  rsp_flag_hold;
   logic                  rsp_flag_released;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int   pending_beats;
   int   fail_total;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   int   stall_left = 0;
   logic gaps_on = 1'b1;

   button_debounce_hold_detector_core DUT (.*);

   bdh_button_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result channel in short random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // End the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, pending_beats);
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one item, after an optional gap, and hold it until accepted
   task automatic send_item(bdh_cmd_type cmd, logic pin, logic dir, logic [SEL_W-1:0] sel);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_pressed    <= pin;
      req_enc_dir    <= dir;
      req_button_sel <= sel;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Stop offering items and wait until every result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (4) @(posedge clock);
   endtask

   // One setup and access phase; psel stays high for back-to-back transfers
   task automatic csr_access(bdh_reg_type idx, logic wr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Write all three registers with noise in the unused bits, then read them back
   task automatic set_limits(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] hold, logic tm);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[CFG_W-1:0] = deb;
      csr_access(REG_DEBOUNCE, 1'b1, word);
      word = $urandom;
      word[CFG_W-1:0] = hold;
      csr_access(REG_HOLD, 1'b1, word);
      word = $urandom;
      word[0] = tm;
      csr_access(REG_TESTING, 1'b1, word);
      csr_access(REG_DEBOUNCE, 1'b0, '0);
      csr_access(REG_HOLD, 1'b0, '0);
      csr_access(REG_TESTING, 1'b0, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] deb, hold;
      logic             tm, pin, level;
      int               run_left, run_max, roll;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: every command, each slot, the missing slot, encoder both ways
      send_item(CMD_TICK, 1'b0, 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b1, 1'($urandom), 2'($urandom));
      send_item(CMD_READ, 1'($urandom), 1'($urandom), SLOT_MAIN);
      send_item(CMD_ENC_STEP, 1'($urandom), 1'b0, 2'($urandom));
      send_item(CMD_ENC_STEP, 1'($urandom), 1'b1, 2'($urandom));
      send_item(CMD_READ, 1'($urandom), 1'($urandom), SLOT_LEFT);
      send_item(CMD_READ, 1'($urandom), 1'($urandom), SLOT_LEFT);
      send_item(CMD_READ, 1'($urandom), 1'($urandom), SLOT_RIGHT);
      send_item(CMD_READ, 1'($urandom), 1'($urandom), SEL_NONE);
      send_item(CMD_CLR_BREAK, 1'($urandom), 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b0, 1'($urandom), 2'($urandom));
      send_item(CMD_READ, 1'($urandom), 1'($urandom), SLOT_MAIN);
      wait_drained();

      // Zero limits in testing mode: walk every state and the paths back from PUSH_DB and PUSHED
      set_limits('0, '0, 1'b1);
      send_item(CMD_TICK, 1'b1, 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b1, 1'($urandom), 2'($urandom));
      send_item(CMD_READ, 1'($urandom), 1'($urandom), SLOT_MAIN);
      send_item(CMD_CLR_BREAK, 1'($urandom), 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b1, 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b0, 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b1, 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b0, 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b0, 1'($urandom), 2'($urandom));
      send_item(CMD_READ, 1'($urandom), 1'($urandom), SLOT_MAIN);
      send_item(CMD_TICK, 1'b1, 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b0, 1'($urandom), 2'($urandom));
      send_item(CMD_TICK, 1'b0, 1'($urandom), 2'($urandom));
      wait_drained();

      // Random phases: press and release runs with bounces, reads and encoder steps
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       begin deb = 1;     hold = 1;     tm = 1'b1; end
            1:       begin deb = 2;     hold = 3;     tm = 1'b0; end
            2:       begin deb = 1;     hold = 65535; tm = 1'b1; end
            3:       begin deb = 65535; hold = 1;     tm = 1'b0; end
            4:       begin deb = 3;     hold = 6;     tm = 1'b1; end
            6:       begin deb = 4;     hold = 2;     tm = 1'b1; end
            default: begin
               deb  = CFG_W'($urandom_range(1, 6));
               hold = CFG_W'($urandom_range(1, 12));
               tm   = 1'($urandom);
            end
         endcase
         gaps_on = (ph != 4 && ph != PHASES - 1);
         set_limits(deb, hold, tm);
         run_max = int'(deb) + int'(hold) + 3;
         if (run_max > 24)
            run_max = 24;
         run_left = 0;
         level    = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
               // flip the button level when the current run is used up
               if (run_left == 0) begin
                  level    = ~level;
                  run_left = $urandom_range(1, run_max);
               end
               run_left--;
               pin = ($urandom_range(0, 19) == 0) ? ~level : level;
               send_item(CMD_TICK, pin, 1'($urandom), 2'($urandom));
            end else if (roll < 86) begin
               send_item(CMD_READ, 1'($urandom), 1'($urandom),
                         ($urandom_range(0, 9) == 0) ? SEL_NONE : 2'($urandom_range(0, 2)));
            end else if (roll < 93) begin
               send_item(CMD_ENC_STEP, 1'($urandom), 1'($urandom), 2'($urandom));
            end else begin
               send_item(CMD_CLR_BREAK, 1'($urandom), 1'($urandom), 2'($urandom));
            end
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("covered %0d items under %0d register settings, including zero and full-scale",
               items_sent, PHASES + 2);
      $display("limits, testing mode on and off, and random gaps and stalls on both channels");
      if (fail_total == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
